/* sv/nrcw_pkg.sv */
package nrcw_pkg;

    // Fixed field widths
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 16;
    localparam int TIME_W     = 48;
    localparam int FIELD_W    = 48;
    localparam int DATAGRAM_W = 16;
    localparam int MIN_WIN_W  = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int PROD_W     = DATAGRAM_W + BYTE_W;

    // Event codes
    localparam logic [OP_W-1:0] OP_SENT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ACKED = 2'd1;
    localparam logic [OP_W-1:0] OP_LOST  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATAGRAM_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM_WINDOW    = 1'b1;

    // Reset values
    localparam logic [31:0]           INITIAL_WINDOW   = 32'd14720;
    localparam logic [DATAGRAM_W-1:0] RESET_DATAGRAM   = 16'd1200;
    localparam logic [MIN_WIN_W-1:0]  RESET_MIN_WINDOW = 20'd2400;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] byte_count;
        logic [TIME_W-1:0] packet_sent_time;
        logic [TIME_W-1:0] current_time;
    } t_in_req;

    typedef struct packed {
        logic               can_send;
        logic [FIELD_W-1:0] available_window;
        logic [FIELD_W-1:0] window_bytes;
        logic [FIELD_W-1:0] slow_start_threshold;
        logic [FIELD_W-1:0] flight_bytes;
        logic               recovering;
    } t_out_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FLIGHT,
        S_ACK,
        S_SLOW,
        S_MUL,
        S_DIV,
        S_GROW,
        S_LOSS,
        S_REPORT
    } t_state;

endpackage

/* sv/nrcw_div.sv */
module nrcw_div #(
    parameter int DIVISOR_W = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nrcw_pkg::PROD_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]        i_divisor,
    output logic                        o_done,
    output logic [nrcw_pkg::PROD_W-1:0] o_quotient
);
    import nrcw_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_count;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [PROD_W-1:0]    r_quo;

    logic [DIVISOR_W:0]   w_trial;
    logic [DIVISOR_W:0]   w_diff;
    logic                 w_ge;

    // One restoring step: shift in the next dividend bit, trial subtract
    assign w_trial = {r_rem, r_quo[PROD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/newreno_congestion_window.sv */
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_in_data  (t_in_req)
// result    out        o_out_valid / i_out_stall  o_out_data (t_out_res)
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// Sent, lost and slow-start ack requests need no divide; a congestion-avoidance
// ack on a nonzero window waits for the growth quotient, which comes from a restoring
// divider that retires one bit a cycle over the 32-bit product.
// o_in_stall is high from acceptance until the result is loaded.
// Synchronous active-low reset restores the initial window and registers.
// A stalled result holds in the output register; the next request is still
// taken and waits at the end of its work until the register frees up.
module newreno_congestion_window #(
    parameter int COUNT_WIDTH = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  nrcw_pkg::t_in_req                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output nrcw_pkg::t_out_res                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [nrcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nrcw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nrcw_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Sequencer and request holding register
    t_state  r_state, n_state;
    t_in_req r_req;

    // Congestion state
    logic [COUNT_WIDTH-1:0] r_cwnd, n_cwnd;
    logic [COUNT_WIDTH-1:0] r_thr, n_thr;
    logic [COUNT_WIDTH-1:0] r_inflight, n_inflight;
    logic                   r_recov, n_recov;
    logic [TIME_W-1:0]      r_rstart, n_rstart;

    // Configuration
    logic [DATAGRAM_W-1:0]  r_mds;
    logic [MIN_WIN_W-1:0]   r_minw;

    // Result register
    logic     r_out_valid, n_out_valid;
    t_out_res r_out, n_out;

    // Shared saturating adder, floor subtractor and divider
    logic [COUNT_WIDTH-1:0] w_add_a, w_add_b, w_add_res;
    logic [COUNT_WIDTH:0]   w_add_sum;
    logic [COUNT_WIDTH-1:0] w_bytes, w_fsub_res;
    logic                   w_div_start, w_div_done;
    logic [PROD_W-1:0]      w_quo;
    logic [COUNT_WIDTH-1:0] w_half, w_minw;
    logic [COUNT_WIDTH-1:0] w_avail;
    logic                   w_can_send, w_out_free;
    logic                   w_in_acc;

    nrcw_div #(
        .DIVISOR_W (COUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (PROD_W'(r_mds) * PROD_W'(r_req.byte_count)),
        .i_divisor  (r_cwnd),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_bytes  = COUNT_WIDTH'(r_req.byte_count);
    assign w_minw   = COUNT_WIDTH'(r_minw);
    assign w_half   = {1'b0, r_cwnd[COUNT_WIDTH-1:1]};
    assign w_in_acc = i_in_valid && !o_in_stall;

    // Saturating add: inflight in the flight step, the window otherwise
    always_comb begin
        w_add_a = (r_state == S_FLIGHT) ? r_inflight : r_cwnd;
        w_add_b = (r_state == S_GROW) ? COUNT_WIDTH'(w_quo) : w_bytes;
    end
    assign w_add_sum  = {1'b0, w_add_a} + {1'b0, w_add_b};
    assign w_add_res  = (w_add_sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                         : w_add_sum[COUNT_WIDTH-1:0];
    // Subtract acked or lost bytes, floor at zero
    assign w_fsub_res = (w_bytes >= r_inflight) ? '0 : r_inflight - w_bytes;

    assign w_can_send = (r_inflight < r_cwnd);
    assign w_avail    = w_can_send ? r_cwnd - r_inflight : '0;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cwnd      = r_cwnd;
        n_thr       = r_thr;
        n_inflight  = r_inflight;
        n_recov     = r_recov;
        n_rstart    = r_rstart;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FLIGHT;
                end
            end
            S_FLIGHT: begin
                // Update bytes in flight (not for a zero-byte ack or unused code), then branch on event kind
                case (r_req.operation)
                    OP_SENT: begin
                        n_inflight = w_add_res;
                        n_state    = S_REPORT;
                    end
                    OP_ACKED: begin
                        if (r_req.byte_count == '0) begin
                            n_state = S_REPORT;
                        end else begin
                            n_inflight = w_fsub_res;
                            n_state    = S_ACK;
                        end
                    end
                    OP_LOST: begin
                        n_inflight = w_fsub_res;
                        n_state    = S_LOSS;
                    end
                    default: begin
                        n_state = S_REPORT;
                    end
                endcase
            end
            S_ACK: begin
                // During recovery, acks of packets sent at or before recovery start leave the window alone
                if (r_recov && (r_req.packet_sent_time <= r_rstart)) begin
                    n_state = S_REPORT;
                end else begin
                    n_recov = 1'b0;
                    n_state = S_SLOW;
                end
            end
            S_SLOW: begin
                if (r_cwnd < r_thr) begin
                    n_cwnd  = w_add_res;
                    n_state = S_REPORT;
                end else if (r_cwnd == '0) begin
                    n_state = S_REPORT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Product is registered inside the divider on start
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                n_cwnd  = w_add_res;
                n_state = S_REPORT;
            end
            S_LOSS: begin
                // Unless inside the current recovery, open a new period: halve the window, floor at minimum
                if (!r_recov || (r_req.packet_sent_time > r_rstart)) begin
                    n_rstart = r_req.current_time;
                    n_recov  = 1'b1;
                    n_thr    = (w_half < w_minw) ? w_minw : w_half;
                    n_cwnd   = (w_half < w_minw) ? w_minw : w_half;
                end
                n_state = S_REPORT;
            end
            S_REPORT: begin
                // Hold until the output register is free, then load the status
                if (w_out_free) begin
                    n_out_valid                = 1'b1;
                    n_out.can_send             = w_can_send;
                    n_out.available_window     = FIELD_W'(w_avail);
                    n_out.window_bytes         = FIELD_W'(r_cwnd);
                    n_out.slow_start_threshold = FIELD_W'(r_thr);
                    n_out.flight_bytes         = FIELD_W'(r_inflight);
                    n_out.recovering           = r_recov;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd      <= COUNT_WIDTH'(INITIAL_WINDOW);
            r_thr       <= COUNT_MAX;
            r_inflight  <= '0;
            r_recov     <= 1'b0;
            r_rstart    <= '0;
            r_out_valid <= 1'b0;
            r_mds       <= RESET_DATAGRAM;
            r_minw      <= RESET_MIN_WINDOW;
        end else begin
            r_cwnd      <= n_cwnd;
            r_thr       <= n_thr;
            r_inflight  <= n_inflight;
            r_recov     <= n_recov;
            r_rstart    <= n_rstart;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_DATAGRAM_SIZE: r_mds  <= i_cfg_data[DATAGRAM_W-1:0];
                    CFG_MINIMUM_WINDOW:    r_minw <= i_cfg_data[MIN_WIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_in_data;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted request always starts at the flight update
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_FLIGHT))
        else $error("accepted request did not start the sequencer");

    // During recovery the window sits at the threshold set by the loss
    a_recov_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recov |-> (r_cwnd == r_thr))
        else $error("window differs from threshold during recovery");

    // Divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide wait");

    // Recovery opens only from the loss step
    a_recov_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_recov) |-> ($past(r_state) == S_LOSS))
        else $error("recovery opened outside the loss step");

endmodule

/* tb/newreno_congestion_window_checker.sv */
`timescale 1ns / 1ps

module newreno_congestion_window_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  nrcw_pkg::t_in_req               i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  nrcw_pkg::t_out_res              i_out_data,
    input  logic                            i_cfg_we,
    input  logic [nrcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nrcw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_slow_acks,
    output int                              o_avoid_acks,
    output int                              o_held_acks,
    output int                              o_new_periods,
    output int                              o_zero_window_acks
);
    import nrcw_pkg::*;

    localparam logic [63:0] COUNT_MAX = 64'h0000_FFFF_FFFF_FFFF;

    // Shadow of the window keeper
    logic [63:0]           cwnd_q;
    logic [63:0]           ssthresh_q;
    logic [63:0]           flight_q;
    logic                  recovering_q;
    logic [TIME_W-1:0]     recovery_start_q;
    logic [DATAGRAM_W-1:0] datagram_q;
    logic [MIN_WIN_W-1:0]  min_window_q;

    t_out_res status_q[$];
    t_out_res want;
    int errors, results, slow_acks, avoid_acks, held_acks, new_periods, zero_window_acks;

    function automatic logic [63:0] add_saturating(input logic [63:0] a, input logic [63:0] b);
        if (a >= COUNT_MAX || b >= COUNT_MAX - a) begin
            return COUNT_MAX;
        end
        return a + b;
    endfunction

    function automatic logic [63:0] sub_floored(input logic [63:0] a, input logic [63:0] b);
        return (b >= a) ? 64'd0 : a - b;
    endfunction

    // Apply one packet event to the shadow state and return the status it reports.
    function automatic t_out_res predict_status(input t_in_req req);
        logic [63:0] bytes;
        logic [63:0] growth;
        logic [63:0] half;
        t_out_res    res;
        bytes = 64'(req.byte_count);
        case (req.operation)
            OP_SENT: begin
                flight_q = add_saturating(flight_q, bytes);
            end
            OP_ACKED: begin
                if (bytes != 0) begin
                    flight_q = sub_floored(flight_q, bytes);
                    if (recovering_q && req.packet_sent_time <= recovery_start_q) begin
                        held_acks++;
                    end else begin
                        recovering_q = 1'b0;
                        if (cwnd_q < ssthresh_q) begin
                            cwnd_q = add_saturating(cwnd_q, bytes);
                            slow_acks++;
                        end else begin
                            if (cwnd_q == 0) begin
                                growth = 64'd0;
                                zero_window_acks++;
                            end else begin
                                growth = (64'(datagram_q) * bytes) / cwnd_q;
                            end
                            cwnd_q = add_saturating(cwnd_q, growth);
                            avoid_acks++;
                        end
                    end
                end
            end
            OP_LOST: begin
                flight_q = sub_floored(flight_q, bytes);
                if (!recovering_q || req.packet_sent_time > recovery_start_q) begin
                    recovery_start_q = req.current_time;
                    recovering_q     = 1'b1;
                    half = cwnd_q >> 1;
                    if (half < 64'(min_window_q)) begin
                        half = 64'(min_window_q);
                    end
                    ssthresh_q = half;
                    cwnd_q     = half;
                    new_periods++;
                end
            end
            default: begin
            end
        endcase
        res.can_send             = flight_q < cwnd_q;
        res.available_window     = (flight_q < cwnd_q) ? FIELD_W'(cwnd_q - flight_q) : '0;
        res.window_bytes         = cwnd_q[FIELD_W-1:0];
        res.slow_start_threshold = ssthresh_q[FIELD_W-1:0];
        res.flight_bytes         = flight_q[FIELD_W-1:0];
        res.recovering           = recovering_q;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [FIELD_W-1:0] exp_v,
                                 input logic [FIELD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cwnd_q           = 64'(INITIAL_WINDOW);
            ssthresh_q       = COUNT_MAX;
            flight_q         = 64'd0;
            recovering_q     = 1'b0;
            recovery_start_q = '0;
            datagram_q       = RESET_DATAGRAM;
            min_window_q     = RESET_MIN_WINDOW;
            status_q.delete();
            errors = 0; results = 0; slow_acks = 0; avoid_acks = 0;
            held_acks = 0; new_periods = 0; zero_window_acks = 0;
        end else begin
            // Retire results first; a request taken on this edge cannot be answered yet.
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (status_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    errors++;
                end else begin
                    want = status_q.pop_front();
                    compare_field("can_send", FIELD_W'(want.can_send), FIELD_W'(i_out_data.can_send));
                    compare_field("available_window", want.available_window,
                                  i_out_data.available_window);
                    compare_field("window_bytes", want.window_bytes, i_out_data.window_bytes);
                    compare_field("slow_start_threshold", want.slow_start_threshold,
                                  i_out_data.slow_start_threshold);
                    compare_field("flight_bytes", want.flight_bytes, i_out_data.flight_bytes);
                    compare_field("recovering", FIELD_W'(want.recovering),
                                  FIELD_W'(i_out_data.recovering));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_DATAGRAM_SIZE) begin
                    datagram_q = i_cfg_data[DATAGRAM_W-1:0];
                end else if (i_cfg_index == CFG_MINIMUM_WINDOW) begin
                    min_window_q = i_cfg_data[MIN_WIN_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(predict_status(i_in_data));
            end
        end
        o_errors           <= errors;
        o_pending          <= status_q.size();
        o_results          <= results;
        o_slow_acks        <= slow_acks;
        o_avoid_acks       <= avoid_acks;
        o_held_acks        <= held_acks;
        o_new_periods      <= new_periods;
        o_zero_window_acks <= zero_window_acks;
    end

endmodule

/* tb/newreno_congestion_window_tb.sv */
`timescale 1ns / 1ps

module newreno_congestion_window_tb;
    import nrcw_pkg::*;

    // Operation code the block must report on without touching its state
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_ONES = '1;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_req            i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_res           o_out_data;

    int errors, pending, results, slow_acks, avoid_acks, held_acks;
    int new_periods, zero_window_acks;

    // Running millisecond clock for the packet events; it only moves forward so
    // that recovery periods always end eventually.
    logic [TIME_W-1:0] now_ms;
    // Set to switch off idling on both channels for one stretch of the run
    logic              steady = 1'b0;
    int                sent_requests = 0;

    always #5 i_clk = ~i_clk;

    newreno_congestion_window DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    newreno_congestion_window_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_in_data          (i_in_data),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_out_data         (o_out_data),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_errors           (errors),
        .o_pending          (pending),
        .o_results          (results),
        .o_slow_acks        (slow_acks),
        .o_avoid_acks       (avoid_acks),
        .o_held_acks        (held_acks),
        .o_new_periods      (new_periods),
        .o_zero_window_acks (zero_window_acks)
    );

    // Stall the result channel at random, with a 38 percent chance, except in the steady stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < 38);
    end

    // Present one request and hold it until the block takes it. Idle cycles go
    // in front of it outside the steady stretch; valid is only raised or lowered once per edge.
    task automatic send_request(input t_in_req req);
        if (!steady) begin
            while ($urandom_range(0, 99) < 38) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sent_requests++;
    endtask

    task automatic send_event(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] bytes,
                              input logic [TIME_W-1:0] sent_ms,
                              input logic [TIME_W-1:0] cur_ms);
        t_in_req req;
        req.operation        = op;
        req.byte_count       = bytes;
        req.packet_sent_time = sent_ms;
        req.current_time     = cur_ms;
        send_request(req);
    endtask

    // Drop valid, then wait until every outstanding status has come back and the
    // block has had time to settle before touching its registers. The pending
    // count is registered from the checker's queue, so wait out that register first.
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges; the block is idle here.
    task automatic set_config(input logic [DATAGRAM_W-1:0] datagram,
                              input logic [MIN_WIN_W-1:0] min_window);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_DATAGRAM_SIZE;
        i_cfg_data  <= CFG_DATA_W'(datagram);
        @(posedge i_clk);
        i_cfg_index <= CFG_MINIMUM_WINDOW;
        i_cfg_data  <= min_window;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] random_time;
        return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
    endfunction

    // Build one random packet event. Acks and losses carry send times just behind
    // the running clock so that some fall inside the current recovery period and
    // some after it. Sent events and the unused code get fully random times in 30 percent of draws.
    function automatic t_in_req next_event(input int loss_pct);
        t_in_req req;
        int      pick;
        int      size_pick;
        pick      = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 99);
        now_ms    = now_ms + TIME_W'($urandom_range(0, 40));
        if (size_pick < 8) begin
            req.byte_count = '0;
        end else if (size_pick < 16) begin
            req.byte_count = '1;
        end else begin
            req.byte_count = BYTE_W'($urandom_range(1, 16'hFFFF));
        end
        if (pick < 3) begin
            req.operation = OP_UNUSED;
        end else if (pick < 3 + loss_pct) begin
            req.operation = OP_LOST;
        end else if (pick < 3 + loss_pct + (97 - loss_pct) / 2) begin
            req.operation = OP_ACKED;
        end else begin
            req.operation = OP_SENT;
        end
        if ((req.operation == OP_SENT || req.operation == OP_UNUSED)
                && $urandom_range(0, 99) < 30) begin
            req.packet_sent_time = random_time();
            req.current_time     = random_time();
        end else begin
            req.packet_sent_time = now_ms - TIME_W'($urandom_range(0, 400));
            req.current_time     = now_ms;
        end
        return req;
    endfunction

    task automatic run_phase(input int count, input int loss_pct);
        repeat (count) send_request(next_event(loss_pct));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events on the reset settings: slow start with the unlimited
        // threshold, ignored zero-byte ack, unused code, then recovery entry,
        // acks held inside recovery, exit into avoidance and repeated losses.
        send_event(OP_SENT,   16'd0,     '0,        '0);
        send_event(OP_SENT,   16'hFFFF,  TIME_ONES, TIME_ONES);
        send_event(OP_SENT,   16'd20000, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        send_event(OP_ACKED,  16'd0,     48'd100,   48'd150);
        send_event(OP_ACKED,  16'd1000,  48'd100,   48'd150);
        send_event(OP_ACKED,  16'hFFFF,  TIME_ONES, '0);
        send_event(OP_UNUSED, 16'hFFFF,  TIME_ONES, TIME_ONES);
        // Zero-byte loss still opens a recovery period.
        send_event(OP_LOST,   16'd0,     48'd200,   48'd1000);
        send_event(OP_ACKED,  16'd500,   48'd900,   48'd1010);
        send_event(OP_LOST,   16'd1200,  48'd1000,  48'd1020);
        send_event(OP_ACKED,  16'd1200,  48'd1001,  48'd1030);
        // Ack larger than the flight: flight floors at zero.
        send_event(OP_ACKED,  16'hFFFF,  48'd1100,  48'd1040);
        send_event(OP_LOST,   16'hFFFF,  48'd1200,  48'd2000);
        send_event(OP_ACKED,  16'd3000,  48'd2001,  48'd2050);
        send_event(OP_SENT,   16'hFFFF,  48'd2090,  48'd2100);
        send_event(OP_LOST,   16'd100,   48'd2050,  48'd2200);
        send_event(OP_LOST,   16'd100,   48'd2300,  48'd2400);
        send_event(OP_UNUSED, 16'd0,     '0,        '0);
        drain();

        // Start the random clock well above the directed times.
        now_ms = {16'($urandom_range(1, 16'h7FFF)), 32'($urandom)};

        set_config(RESET_DATAGRAM, RESET_MIN_WINDOW);
        run_phase(400, 11);
        drain();

        // Largest datagram and floor
        set_config('1, '1);
        run_phase(400, 11);
        drain();

        // Zero datagram and zero floor: losses can drive the window to zero.
        set_config('0, '0);
        run_phase(400, 20);
        drain();

        // Smallest nonzero settings, with no idling on either side
        steady <= 1'b1;
        set_config(DATAGRAM_W'(1), MIN_WIN_W'(1));
        run_phase(350, 11);
        drain();
        steady <= 1'b0;

        set_config(DATAGRAM_W'($urandom_range(1, 16'hFFFF)),
                   MIN_WIN_W'($urandom_range(0, 20'hFFFFF)));
        run_phase(380, 11);
        drain();

        $display("Ran %0d packet events over five register settings, %0d statuses checked.",
                 sent_requests, results);
        $display("Acks: %0d slow start, %0d avoidance (%0d on a zero window), %0d held;",
                 slow_acks, avoid_acks, zero_window_acks, held_acks);
        $display("%0d recoveries opened.", new_periods);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
